// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // field widths of the stream items and registers
    localparam int OP_W     = 2;
    localparam int ID_W     = 12;
    localparam int STATUS_W = 3;
    localparam int BLOCK_W  = 10;
    localparam int OFFSET_W = 41;
    localparam int DOFF_W   = 40;
    localparam int BSIZE_W  = 21;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 72;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 4;

    localparam int DEF_NUM_BLOCKS = 1024;
    localparam int DEF_NUM_IDS    = 4096;

    // free map is kept as 32-bit words
    localparam int MAP_WORD_W = 32;
    localparam int MAP_BIT_W  = 5;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ISSUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;

    // register select is paddr[3]: 0 region base, 1 blob size
    localparam logic REG_DOFF  = 1'b0;
    localparam logic REG_BSIZE = 1'b1;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_TEST  = 9'b000001000,
        S_ENTRY = 9'b000010000,
        S_FREE  = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_ADD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } bba_state_t;

    // index of the lowest set bit of a map word
    function automatic logic [MAP_BIT_W-1:0] lowest_set(input logic [MAP_WORD_W-1:0] w);
        logic [MAP_BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = MAP_BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bitmap_block_allocator_with_id_map.sv =====
// Bitmap block allocator with identifier map.
// Input stream (s_tdata): one operation per transfer: allocate, free, or locate.
// Output stream (m_tdata): exactly one result per input transfer, in order.
// APB port: region base at 0x0, blob_size at 0x8 (64-bit data, pready tied high).
// Sequencer steps from an input transfer to its result:
//   id error or exhausted id space: straight to the result step (S_DONE)
//   allocate: a read (S_SCAN) and a test (S_TEST) per 32-bit map word tested, one more
//     S_SCAN when no block is free; the scan starts at the lowest word that may still
//     hold a free block
//   free: S_ENTRY, S_FREE; locate: S_ENTRY, one 21-bit multiply, then the 41-bit add
// One item is worked at a time; s_tready is high only while the sequencer idles.
// The next item is taken while a result waits in the output register.
// A stalled receiver holds the result in place; the sequencer waits at its
// last step if a second result is ready before the first is taken.
// After reset the free map is swept to all-free, one word per cycle, with s_tready
// low. APB writes work throughout.
// The id table needs no clearing: entries at or above the id counter are never read.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_with_id_map
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int NUM_IDS    = DEF_NUM_IDS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [1:0] operation, [13:2] blob_id
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [2:0] status, [14:3] result_id, [24:15] block_index, [65:25] byte_offset
    output logic      [M_DATA_W-1:0] m_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready
);

    localparam int NUM_WORDS = (NUM_BLOCKS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SA_W      = $clog2(NUM_WORDS + 1);
    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int TA_W      = $clog2(NUM_IDS);
    localparam int CNT_W     = $clog2(NUM_IDS + 1);
    localparam int CMP_W     = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam int PROD_W    = BLK_W + BSIZE_W;
    localparam int TBL_W     = BLK_W + 1;

    function automatic logic [MAP_WORD_W-1:0] init_word(input logic [WA_W-1:0] w);
        logic [MAP_WORD_W-1:0] v;
        v = '0;
        for (int b = 0; b < MAP_WORD_W; b++)
        begin
            v[b] = ((int'(w) * MAP_WORD_W + b) < NUM_BLOCKS);
        end
        return v;
    endfunction

    // memories
    logic [MAP_WORD_W-1:0] free_mem [NUM_WORDS];
    logic [TBL_W-1:0]      tbl_mem  [NUM_IDS];

    logic [MAP_WORD_W-1:0] fm_rdata_reg;
    logic [WA_W-1:0]       fm_raddr;
    logic                  fm_we;
    logic [WA_W-1:0]       fm_waddr;
    logic [MAP_WORD_W-1:0] fm_wdata;

    logic [TBL_W-1:0]      tbl_rdata_reg;
    logic [TA_W-1:0]       tbl_raddr;
    logic                  tbl_we;
    logic [TA_W-1:0]       tbl_waddr;
    logic [TBL_W-1:0]      tbl_wdata;

    // control state
    bba_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SA_W-1:0]       hint_reg, hint_next;
    logic [SA_W-1:0]       scan_reg, scan_next;
    logic [WA_W-1:0]       clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DOFF_W-1:0]     region_base_reg;
    logic [BSIZE_W-1:0]    blob_size_reg;

    // work payload
    logic [OP_W-1:0]       op_reg, op_next;
    logic [CMP_W-1:0]      id_reg, id_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [OFFSET_W-1:0]   res_off_reg, res_off_next;

    // output register
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic [BLOCK_W-1:0]    out_blk_reg, out_blk_next;
    logic [OFFSET_W-1:0]   out_off_reg, out_off_next;

    logic [OP_W-1:0]       in_op;
    logic [ID_W-1:0]       in_id;
    logic                  in_xfer;
    logic                  cfg_wr;
    logic [MAP_BIT_W-1:0]  low_bit;
    logic                  tbl_valid;
    logic [BLK_W-1:0]      tbl_blk;
    logic [WA_W-1:0]       blk_word;
    logic [MAP_BIT_W-1:0]  blk_bit;
    logic [WA_W-1:0]       ent_word;

    assign in_op     = s_tdata[OP_W-1:0];
    assign in_id     = s_tdata[OP_W+ID_W-1:OP_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign low_bit   = lowest_set(fm_rdata_reg);
    assign tbl_valid = tbl_rdata_reg[BLK_W];
    assign tbl_blk   = tbl_rdata_reg[BLK_W-1:0];
    assign blk_word  = WA_W'(blk_reg >> MAP_BIT_W);
    assign blk_bit   = MAP_BIT_W'(blk_reg);
    assign ent_word  = WA_W'(tbl_blk >> MAP_BIT_W);
    assign tbl_raddr = TA_W'(in_id);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_off_reg, out_blk_reg, out_id_reg, out_status_reg});

    always_comb
    begin
        if (paddr[3] == REG_BSIZE)
        begin
            prdata = APB_DW'(blob_size_reg);
        end
        else
        begin
            prdata = APB_DW'(region_base_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        hint_next       = hint_reg;
        scan_next       = scan_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        blk_next        = blk_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_blk_next    = out_blk_reg;
        out_off_next    = out_off_reg;
        fm_raddr        = WA_W'(scan_reg);
        fm_we           = 1'b0;
        fm_waddr        = clr_reg;
        fm_wdata        = init_word(clr_reg);
        tbl_we          = 1'b0;
        tbl_waddr       = TA_W'(id_reg);
        tbl_wdata       = {1'b0, blk_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                fm_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WA_W'(NUM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next      = in_op;
                    res_off_next = '0;
                    blk_next     = '0;
                    if (in_op == OP_ALLOC)
                    begin
                        if (cnt_reg == CNT_W'(NUM_IDS))
                        begin
                            id_next         = '0;
                            res_status_next = ST_EXHAUSTED;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            id_next    = CMP_W'(cnt_reg);
                            cnt_next   = cnt_reg + 1'b1;
                            scan_next  = hint_reg;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        id_next = CMP_W'(in_id);
                        if (CMP_W'(in_id) >= CMP_W'(cnt_reg))
                        begin
                            res_status_next = ST_NOT_ISSUED;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ENTRY;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg == SA_W'(NUM_WORDS))
                begin
                    // map full: the id is spent but stays invalid
                    tbl_we          = 1'b1;
                    tbl_wdata       = '0;
                    res_status_next = ST_NO_BLOCK;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (fm_rdata_reg != '0)
                begin
                    blk_next        = BLK_W'({WA_W'(scan_reg), low_bit});
                    fm_we           = 1'b1;
                    fm_waddr        = WA_W'(scan_reg);
                    fm_wdata        = fm_rdata_reg & ~(MAP_WORD_W'(1) << low_bit);
                    tbl_we          = 1'b1;
                    tbl_wdata       = {1'b1, BLK_W'({WA_W'(scan_reg), low_bit})};
                    hint_next       = scan_reg;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    // every word below the hint is full
                    scan_next  = scan_reg + 1'b1;
                    hint_next  = scan_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_ENTRY:
            begin
                if (!tbl_valid)
                begin
                    res_status_next = ST_FREED;
                    state_next      = S_DONE;
                end
                else
                begin
                    blk_next = tbl_blk;
                    if (op_reg == OP_FREE)
                    begin
                        tbl_we     = 1'b1;
                        tbl_wdata  = {1'b0, tbl_blk};
                        fm_raddr   = ent_word;
                        state_next = S_FREE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_FREE:
            begin
                fm_we    = 1'b1;
                fm_waddr = blk_word;
                fm_wdata = fm_rdata_reg | (MAP_WORD_W'(1) << blk_bit);
                if (SA_W'(blk_word) < hint_reg)
                begin
                    hint_next = SA_W'(blk_word);
                end
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(blk_reg) * PROD_W'(blob_size_reg);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_off_next    = OFFSET_W'(region_base_reg) + OFFSET_W'(prod_reg);
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = ID_W'(id_reg);
                    out_blk_next    = BLOCK_W'(blk_reg);
                    out_off_next    = res_off_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            hint_reg        <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            region_base_reg <= '0;
            blob_size_reg   <= BSIZE_W'(4096);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hint_reg      <= hint_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                if (paddr[3] == REG_BSIZE)
                begin
                    blob_size_reg <= pwdata[BSIZE_W-1:0];
                end
                else
                begin
                    region_base_reg <= pwdata[DOFF_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        op_reg         <= op_next;
        id_reg         <= id_next;
        blk_reg        <= blk_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_blk_reg    <= out_blk_next;
        out_off_reg    <= out_off_next;
    end

    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            free_mem[fm_waddr] <= fm_wdata;
        end
        fm_rdata_reg <= free_mem[fm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    a_cnt_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_op == OP_ALLOC && cnt_reg != CNT_W'(NUM_IDS))
        |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("id counter did not advance on allocate");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NUM_IDS))
        else $error("id counter past id space");

    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= SA_W'(NUM_WORDS))
        else $error("scan hint out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_blk_reg == '0 && out_off_reg == '0))
        else $error("error result carries block or offset");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bba_pkg::*;

    localparam int N_BLOCKS   = DEF_NUM_BLOCKS;
    localparam int N_IDS      = DEF_NUM_IDS;
    localparam int MAX_CYCLES = 2_000_000;
    localparam int RES_W      = OFFSET_W + BLOCK_W + ID_W + STATUS_W;

    // locate is any code other than allocate or free, so both codes locate
    localparam logic [OP_W-1:0] OP_LOCATE    = 2'd2;
    localparam logic [OP_W-1:0] OP_LOCATE_HI = 2'd3;

    // same layout as m_tdata, status in the lowest bits
    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [BLOCK_W-1:0]  block_index;
        logic [ID_W-1:0]     result_id;
        logic [STATUS_W-1:0] status;
    } alloc_result_t;

    typedef struct packed {
        logic          typed;
        alloc_result_t res;
    } item_note_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     id;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     rid;
        logic [BLOCK_W-1:0]  blk;
    } dir_row_t;

    localparam int N_DIR = 19;
    // typed rows assume a fresh block; locate offsets come from the predictor
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{OP_LOCATE,    12'd0,    1'b1, ST_NOT_ISSUED, 12'd0,    10'd0},
        '{OP_FREE,      12'd4095, 1'b1, ST_NOT_ISSUED, 12'd4095, 10'd0},
        '{OP_ALLOC,     12'd0,    1'b1, ST_OK,         12'd0,    10'd0},
        '{OP_ALLOC,     12'd0,    1'b1, ST_OK,         12'd1,    10'd1},
        '{OP_ALLOC,     12'd4095, 1'b1, ST_OK,         12'd2,    10'd2},
        '{OP_LOCATE,    12'd0,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_LOCATE_HI, 12'd2,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_FREE,      12'd1,    1'b1, ST_OK,         12'd1,    10'd1},
        '{OP_FREE,      12'd1,    1'b1, ST_FREED,      12'd1,    10'd0},
        '{OP_LOCATE,    12'd1,    1'b1, ST_FREED,      12'd1,    10'd0},
        '{OP_ALLOC,     12'd0,    1'b1, ST_OK,         12'd3,    10'd1},
        '{OP_LOCATE,    12'd3,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_LOCATE,    12'd4,    1'b1, ST_NOT_ISSUED, 12'd4,    10'd0},
        '{OP_LOCATE_HI, 12'd4095, 1'b1, ST_NOT_ISSUED, 12'd4095, 10'd0},
        '{OP_FREE,      12'd3,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_FREE,      12'd0,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_LOCATE_HI, 12'd2,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_FREE,      12'd2,    1'b0, ST_OK,         12'd0,    10'd0},
        '{OP_LOCATE,    12'd2,    1'b1, ST_FREED,      12'd2,    10'd0}
    };

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // predictor state
    logic [DOFF_W-1:0]  doff  = '0;
    logic [BSIZE_W-1:0] bsize = 21'd4096;
    bit                 blk_free [N_BLOCKS] = '{default: 1'b1};
    bit                 id_live  [N_IDS]    = '{default: 1'b0};
    logic [BLOCK_W-1:0] id_blk   [N_IDS];
    int                 id_ctr = 0;
    int                 n_free = N_BLOCKS;

    item_note_t    note_q [$];
    alloc_result_t result_q [$];
    int            errors     = 0;
    int            cycles     = 0;
    int            burst_left = 0;
    int            rx_mode    = 0;
    int            rx_left    = 0;

    bitmap_block_allocator_with_id_map dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == MAX_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // applies one operation to the allocator state and returns its result
    function automatic alloc_result_t apply_op(input logic [OP_W-1:0] op,
                                               input logic [ID_W-1:0] id);
        alloc_result_t r;
        int            blk;
        r = '0;
        if (op == OP_ALLOC)
        begin
            if (id_ctr >= N_IDS)
            begin
                r.status = ST_EXHAUSTED;
                return r;
            end
            r.result_id = ID_W'(id_ctr);
            id_ctr++;
            blk = -1;
            for (int b = 0; b < N_BLOCKS && blk < 0; b++)
            begin
                if (blk_free[b])
                begin
                    blk = b;
                end
            end
            if (blk < 0)
            begin
                r.status = ST_NO_BLOCK;
            end
            else
            begin
                blk_free[blk]       = 1'b0;
                n_free--;
                id_live[r.result_id] = 1'b1;
                id_blk[r.result_id]  = BLOCK_W'(blk);
                r.status             = ST_OK;
                r.block_index        = BLOCK_W'(blk);
            end
            return r;
        end
        r.result_id = id;
        if (int'(id) >= id_ctr)
        begin
            r.status = ST_NOT_ISSUED;
        end
        else if (!id_live[id])
        begin
            r.status = ST_FREED;
        end
        else
        begin
            r.status      = ST_OK;
            r.block_index = id_blk[id];
            if (op == OP_FREE)
            begin
                blk_free[id_blk[id]] = 1'b1;
                n_free++;
                id_live[id]          = 1'b0;
            end
            else
            begin
                r.byte_offset = OFFSET_W'(64'(doff) + 64'(id_blk[id]) * 64'(bsize));
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // scoreboard: expectation on the input transfer, compare on the output transfer
    always @(posedge clk)
    begin : track
        item_note_t    note;
        alloc_result_t want;
        alloc_result_t got;
        if (s_tvalid && s_tready)
        begin
            note = note_q.pop_front();
            want = apply_op(s_tdata[OP_W-1:0], s_tdata[OP_W+ID_W-1:OP_W]);
            if (note.typed)
            begin
                want = note.res;
            end
            result_q.push_back(want);
        end
        if (m_tvalid && m_tready)
        begin
            got = alloc_result_t'(m_tdata[RES_W-1:0]);
            if (result_q.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("result_id", 64'(want.result_id), 64'(got.result_id));
                check_field("block_index", 64'(want.block_index), 64'(got.block_index));
                check_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
            end
        end
    end

    // receiver: switches between always ready, coin-flip and mostly stalled
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic reg_write(input logic rsel, input logic [APB_DW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rsel, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (rsel == REG_DOFF)
        begin
            doff = DOFF_W'(val);
        end
        else
        begin
            bsize = BSIZE_W'(val);
        end
    endtask

    task automatic push_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic typed, input alloc_result_t res);
        int gap;
        note_q.push_back('{typed: typed, res: res});
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({id, op});
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // mostly identifiers already issued, recent ones favored; some near or past the counter
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (id_ctr > 0 && r < 8)
        begin
            if (r < 4 && id_ctr > 64)
            begin
                return ID_W'($urandom_range(id_ctr - 64, id_ctr - 1));
            end
            return ID_W'($urandom_range(0, id_ctr - 1));
        end
        if (r == 8)
        begin
            return ID_W'(id_ctr + $urandom_range(0, 3));
        end
        return ID_W'($urandom);
    endfunction

    task automatic send_random(input int alloc_pct);
        logic [OP_W-1:0] op;
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            op = OP_ALLOC;
        end
        else if ($urandom_range(0, 99) < 45)
        begin
            op = OP_FREE;
        end
        else
        begin
            op = $urandom_range(0, 1) ? OP_LOCATE : OP_LOCATE_HI;
        end
        push_item(op, (op == OP_ALLOC) ? ID_W'($urandom) : pick_id(), 1'b0, '0);
    endtask

    // stops the sender until every outstanding transfer has its result
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (note_q.size() + result_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        alloc_result_t res;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        reg_write(REG_DOFF, 64'd0);
        reg_write(REG_BSIZE, 64'd512);
        for (int i = 0; i < N_DIR; i++)
        begin
            res             = '0;
            res.status      = DIR_ROWS[i].status;
            res.result_id   = DIR_ROWS[i].rid;
            res.block_index = DIR_ROWS[i].blk;
            push_item(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].typed, res);
        end

        drain();
        reg_write(REG_DOFF, 64'hFF_FFFF_FFFF);
        reg_write(REG_BSIZE, 64'd1048576);
        repeat (100) send_random(40);

        drain();
        reg_write(REG_DOFF, 64'(DOFF_W'({$urandom, $urandom})));
        reg_write(REG_BSIZE, 64'($urandom_range(512, 1048576)));
        for (int i = 0; i < 150; i++)
        begin
            if (i == 75)
            begin
                drain();
            end
            send_random(60);
        end

        // allocate-heavy: runs the map full, then allocates against the full map
        drain();
        reg_write(REG_DOFF, 64'(DOFF_W'({$urandom, $urandom})));
        reg_write(REG_BSIZE, 64'd4096);
        while (n_free > 0)
            send_random(97);
        repeat (4) send_random(100);
        repeat (60) send_random(30);

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bitmap_block_allocator_with_id_map.sv
test/tb_top.sv
